### rtl/odp_pkg.sv
package odp_pkg;

   // Palette geometry.
   localparam int RED_LEVELS   = 7;
   localparam int GREEN_LEVELS = 9;
   localparam int BLUE_LEVELS  = 4;

   localparam int MAX_LEVELS_RG = (RED_LEVELS > GREEN_LEVELS) ? RED_LEVELS : GREEN_LEVELS;
   localparam int MAX_LEVELS    = (MAX_LEVELS_RG > BLUE_LEVELS) ? MAX_LEVELS_RG : BLUE_LEVELS;

   // Widths of the datapath.
   localparam int CHANNEL_W = 8;
   localparam int PHASE_W   = 3;
   localparam int THRESH_W  = 6;
   localparam int CURVE_W   = 17;
   localparam int OFFSET_W  = 16;
   localparam int FRAC_W    = 16;
   localparam int LEVEL_W   = $clog2(MAX_LEVELS);
   localparam int INDEX_W   = 8;
   localparam int INDEX_SUM_W = 16;
   localparam int PIXEL_W   = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   localparam int CURVE_DEPTH  = 2 ** CHANNEL_W;
   localparam int OFFSET_DEPTH = 2 ** THRESH_W;

   // Highest level number of each channel.
   localparam logic [LEVEL_W-1:0] RED_TOP   = LEVEL_W'(RED_LEVELS - 1);
   localparam logic [LEVEL_W-1:0] GREEN_TOP = LEVEL_W'(GREEN_LEVELS - 1);
   localparam logic [LEVEL_W-1:0] BLUE_TOP  = LEVEL_W'(BLUE_LEVELS - 1);

   // Index weights: red * G * B + green * B + blue.
   localparam logic [INDEX_SUM_W-1:0] RED_WEIGHT   = INDEX_SUM_W'(GREEN_LEVELS * BLUE_LEVELS);
   localparam logic [INDEX_SUM_W-1:0] GREEN_WEIGHT = INDEX_SUM_W'(BLUE_LEVELS);
   localparam logic [INDEX_W-1:0] MAX_INDEX =
      INDEX_W'(RED_LEVELS * GREEN_LEVELS * BLUE_LEVELS - 1);

   // Configuration register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STRENGTH_W = 3;
   localparam logic [0:0] CSR_STRENGTH_INDEX = 1'b0;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 3'd6;
   localparam logic [THRESH_W-1:0] THRESH_ALL = 6'h3F;

   // Constants of the level curves.
   localparam longint unsigned CurveDivisor = 64'd65025;
   localparam longint unsigned OffsetBase   = 64'd65280;

   typedef logic [CURVE_W-1:0]  curve_table_type  [CURVE_DEPTH];
   typedef logic [OFFSET_W-1:0] offset_table_type [OFFSET_DEPTH];

   // Integer cube root, for values up to 2^48.
   function automatic logic [63:0] int_cbrt(input logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 64'd0;
      hi = 64'd65537;
      while (hi - lo > 64'd1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid * mid <= v) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   // Integer square root of a 64-bit value.
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 64'd0;
      hi = 64'h1_0000_0000;
      while (hi - lo > 64'd1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= v) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   // Channel curve in Q16: 65536 * (c/255)^(2/3), evaluated at elaboration.
   function automatic curve_table_type build_curve_table();
      curve_table_type tbl;
      logic [63:0] sq;
      for (int c = 0; c < CURVE_DEPTH; c++) begin
         sq = 64'(c) * 64'(c);
         tbl[c] = CURVE_W'(int_cbrt((sq << 48) / CurveDivisor));
      end
      return tbl;
   endfunction

   // Threshold offset in Q16: 255/256 - (m/64)^(3/4).
   function automatic offset_table_type build_offset_table();
      offset_table_type tbl;
      logic [63:0] cube;
      for (int m = 0; m < OFFSET_DEPTH; m++) begin
         cube = 64'(m) * 64'(m) * 64'(m);
         tbl[m] = OFFSET_W'(OffsetBase - int_sqrt(int_sqrt(cube << 46)));
      end
      return tbl;
   endfunction

   localparam curve_table_type  CURVE_TABLE  = build_curve_table();
   localparam offset_table_type OFFSET_TABLE = build_offset_table();

endpackage

### rtl/odp_curve_rom.sv
// Synchronous ROM holding the gamma-shaped channel curve, one read per cycle while rd_en is high.
module odp_curve_rom (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [odp_pkg::CHANNEL_W-1:0] rd_addr,
   output logic [odp_pkg::CURVE_W-1:0]   rd_data
);

   logic [odp_pkg::CURVE_W-1:0] rom_mem [odp_pkg::CURVE_DEPTH];
   logic [odp_pkg::CURVE_W-1:0] rd_data_ff;

   assign rom_mem = odp_pkg::CURVE_TABLE;

   // Registered read; the data holds while the pipeline stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/odp_level.sv
// Turns one channel's curve value and the threshold offset into a palette level.
module odp_level (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [odp_pkg::CURVE_W-1:0]   curve,
   input  logic [odp_pkg::OFFSET_W-1:0]  offset,
   input  logic [odp_pkg::LEVEL_W-1:0]   top_level,
   output logic [odp_pkg::LEVEL_W-1:0]   level
);

   localparam int SUM_W = odp_pkg::CURVE_W + odp_pkg::LEVEL_W + 1;
   localparam int RAW_W = SUM_W - odp_pkg::FRAC_W;

   logic [SUM_W-1:0]            scaled_sum;
   logic [RAW_W-1:0]            raw_level;
   logic [odp_pkg::LEVEL_W-1:0] level_in;
   logic [odp_pkg::LEVEL_W-1:0] level_ff;

   // Scale the curve to the level range, add the offset and drop the fraction.
   always_comb begin
      scaled_sum = SUM_W'(curve) * SUM_W'(top_level) + SUM_W'(offset);
      raw_level  = scaled_sum[SUM_W-1:odp_pkg::FRAC_W];
      if (raw_level > RAW_W'(top_level)) begin
         level_in = top_level;
      end else begin
         level_in = raw_level[odp_pkg::LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

### rtl/odp_csr.sv
// Configuration register file: holds the dither strength.
module odp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [odp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [odp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [odp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [odp_pkg::STRENGTH_W-1:0]   dither_strength
);

   logic                             strength_hit;
   logic                             write_strobe;
   logic [odp_pkg::STRENGTH_W-1:0]   strength_in;
   logic [odp_pkg::STRENGTH_W-1:0]   strength_ff;

   // Word index decode; the low address bits select a byte and are ignored.
   assign strength_hit = (csr_paddr[odp_pkg::CSR_ADDR_W-1] == odp_pkg::CSR_STRENGTH_INDEX);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      strength_in = strength_ff;
      if (write_strobe && strength_hit) begin
         strength_in = csr_pwdata[odp_pkg::STRENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= odp_pkg::STRENGTH_RESET;
      end else begin
         strength_ff <= strength_in;
      end
   end

   // Reads return the register; unmapped addresses read as zero.
   assign csr_prdata = strength_hit ? odp_pkg::CSR_DATA_W'(strength_ff) : '0;
   assign csr_pready = 1'b1;
   assign dither_strength = strength_ff;

endmodule

### rtl/ordered_dither_rgb_to_palette_core.sv
// Ordered-dither color reducer. Each transaction on the req_ channel carries one RGBA pixel
// and the low three bits of its column and row; the rsp_ channel returns an 8-bit index into
// a 7x9x4 regular palette (red*36 + green*4 + blue). The block takes one pixel every clock
// while the output is not stalled. It passes three register stages: one for the
// synchronous curve and threshold ROM reads, one for the per-channel level multiply-add,
// and one for the index sum in the output register. A stalled output only holds back the
// stages behind it that are full, so bubbles in the pipeline are squeezed out. The dither
// strength register (byte address 0, reset 6) keeps that many top bits of the 8x8 Bayer
// threshold; 0 turns dithering off and 7 acts like 6. Write it only while no pixel is in
// flight.
module ordered_dither_rgb_to_palette_core (
   input  logic                               clock,
   input  logic                               reset,
   // Input pixel transactions.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] pixel_rgba, [34:32] column_phase, [37:35] row_phase, [39:38] zero
   input  logic [odp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Palette index transactions.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] palette_index
   output logic [odp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [odp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [odp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [odp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [odp_pkg::STRENGTH_W-1:0] dither_strength;

   logic [odp_pkg::PIXEL_W-1:0]    pixel_rgba;
   logic [odp_pkg::PHASE_W-1:0]    column_phase;
   logic [odp_pkg::PHASE_W-1:0]    row_phase;
   logic [odp_pkg::PHASE_W-1:0]    phase_xor;
   logic [odp_pkg::THRESH_W-1:0]   threshold;
   logic [odp_pkg::THRESH_W-1:0]   thresh_mask;
   logic [odp_pkg::THRESH_W-1:0]   masked_thresh;

   logic                           req_fire;
   logic                           s1_advance;
   logic                           s2_advance;
   logic                           out_advance;

   logic                           s1_valid_in;
   logic                           s1_valid_ff;
   logic                           s2_valid_in;
   logic                           s2_valid_ff;
   logic                           out_valid_in;
   logic                           out_valid_ff;

   logic [odp_pkg::CURVE_W-1:0]    red_curve;
   logic [odp_pkg::CURVE_W-1:0]    green_curve;
   logic [odp_pkg::CURVE_W-1:0]    blue_curve;
   logic [odp_pkg::OFFSET_W-1:0]   offset_ff;

   logic [odp_pkg::LEVEL_W-1:0]    red_level;
   logic [odp_pkg::LEVEL_W-1:0]    green_level;
   logic [odp_pkg::LEVEL_W-1:0]    blue_level;

   logic [odp_pkg::INDEX_SUM_W-1:0] index_sum;
   logic [odp_pkg::INDEX_W-1:0]     index_in;
   logic [odp_pkg::INDEX_W-1:0]     index_ff;

   // Configuration registers.
   odp_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .dither_strength (dither_strength)
   );

   // Unpack the input transaction.
   assign pixel_rgba   = req_tdata[odp_pkg::PIXEL_W-1:0];
   assign column_phase = req_tdata[odp_pkg::PIXEL_W +: odp_pkg::PHASE_W];
   assign row_phase    = req_tdata[odp_pkg::PIXEL_W + odp_pkg::PHASE_W +: odp_pkg::PHASE_W];

   // Bayer threshold: bits of x and x^y interleaved, most significant bits reversed.
   assign phase_xor     = column_phase ^ row_phase;
   assign threshold     = {phase_xor[0], column_phase[0], phase_xor[1],
                           column_phase[1], phase_xor[2], column_phase[2]};
   assign thresh_mask   = odp_pkg::THRESH_ALL & ~(odp_pkg::THRESH_ALL >> dither_strength);
   assign masked_thresh = threshold & thresh_mask;

   // Each stage moves on when it is empty or the stage after it moves.
   assign out_advance = !out_valid_ff || rsp_tready;
   assign s2_advance  = !s2_valid_ff || out_advance;
   assign s1_advance  = !s1_valid_ff || s2_advance;
   assign req_tready  = s1_advance;
   assign req_fire    = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = s1_advance  ? req_fire    : s1_valid_ff;
      s2_valid_in  = s2_advance  ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_advance ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Stage one: curve lookups for the three channels and the threshold offset.
   odp_curve_rom u_red_rom (
      .clock   (clock),
      .rd_en   (s1_advance),
      .rd_addr (pixel_rgba[7:0]),
      .rd_data (red_curve)
   );

   odp_curve_rom u_green_rom (
      .clock   (clock),
      .rd_en   (s1_advance),
      .rd_addr (pixel_rgba[15:8]),
      .rd_data (green_curve)
   );

   odp_curve_rom u_blue_rom (
      .clock   (clock),
      .rd_en   (s1_advance),
      .rd_addr (pixel_rgba[23:16]),
      .rd_data (blue_curve)
   );

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         offset_ff <= odp_pkg::OFFSET_TABLE[masked_thresh];
      end
   end

   // Stage two: palette level of each channel.
   odp_level u_red_level (
      .clock     (clock),
      .advance   (s2_advance),
      .curve     (red_curve),
      .offset    (offset_ff),
      .top_level (odp_pkg::RED_TOP),
      .level     (red_level)
   );

   odp_level u_green_level (
      .clock     (clock),
      .advance   (s2_advance),
      .curve     (green_curve),
      .offset    (offset_ff),
      .top_level (odp_pkg::GREEN_TOP),
      .level     (green_level)
   );

   odp_level u_blue_level (
      .clock     (clock),
      .advance   (s2_advance),
      .curve     (blue_curve),
      .offset    (offset_ff),
      .top_level (odp_pkg::BLUE_TOP),
      .level     (blue_level)
   );

   // Stage three: combine the levels into the palette index.
   always_comb begin
      index_sum = odp_pkg::INDEX_SUM_W'(red_level) * odp_pkg::RED_WEIGHT
                + odp_pkg::INDEX_SUM_W'(green_level) * odp_pkg::GREEN_WEIGHT
                + odp_pkg::INDEX_SUM_W'(blue_level);
      index_in  = index_sum[odp_pkg::INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (out_advance) begin
         index_ff <= index_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = odp_pkg::RSP_DATA_W'(index_ff);

   // An accepted pixel always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted pixel did not enter the first stage");

   // A full stage that cannot move keeps its item.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_advance |=> s2_valid_ff)
      else $error("level stage dropped an item while stalled");

   // Levels never exceed the top level of their channel.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (red_level <= odp_pkg::RED_TOP) && (green_level <= odp_pkg::GREEN_TOP)
                      && (blue_level <= odp_pkg::BLUE_TOP))
      else $error("channel level out of range");

   // The palette index stays within the palette.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= odp_pkg::MAX_INDEX)
      else $error("palette index out of range");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s2_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

### test/dither_index_checker.sv
module dither_index_checker #(
   parameter logic [odp_pkg::CSR_ADDR_W-1:0] STRENGTH_ADDR = '0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [31:0] pixel_rgba, [34:32] column_phase, [37:35] row_phase, [39:38] zero
   input  logic [odp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] palette_index
   input  logic [odp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [odp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [odp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [odp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  logic                            csr_pready,
   output int                              failures,
   output int                              in_flight
);
   import odp_pkg::*;

   // 255 squared scales a channel to the unit range; 65280 is 255/256 in Q16.
   localparam longint unsigned FULL_SCALE_SQ = 64'd65025;
   localparam longint unsigned OFFSET_CEIL   = 64'd65280;

   typedef struct packed {
      logic [INDEX_W-1:0]   index;
      logic [PIXEL_W-1:0]   pixel;
      logic [PHASE_W-1:0]   col;
      logic [PHASE_W-1:0]   row;
   } pixel_result_t;

   pixel_result_t           expected_results[$];
   pixel_result_t           fresh;
   pixel_result_t           oldest;
   logic [STRENGTH_W-1:0]   strength_copy;

   // Largest r with r*r*r <= v, built one bit at a time.
   function automatic longint unsigned cube_root_floor(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int bit_pos = 16; bit_pos >= 0; bit_pos--) begin
         trial = root | (64'd1 << bit_pos);
         if (trial * trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Largest r with r^4 <= v.
   function automatic longint unsigned fourth_root_floor(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int bit_pos = 15; bit_pos >= 0; bit_pos--) begin
         trial = root | (64'd1 << bit_pos);
         if (trial * trial * trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Gamma curve of one channel, scaled to the level count and offset by the threshold.
   function automatic int unsigned channel_level(input logic [CHANNEL_W-1:0] channel,
                                                 input int unsigned levels,
                                                 input longint unsigned offset);
      longint unsigned square;
      longint unsigned curve;
      longint unsigned top;
      longint unsigned level;
      square = 64'(channel) * 64'(channel);
      curve  = cube_root_floor((square << 48) / FULL_SCALE_SQ);
      top    = 64'(levels - 1);
      level  = (curve * top + offset) >> 16;
      return (level < top) ? int'(level) : int'(top);
   endfunction

   function automatic logic [INDEX_W-1:0] predict_palette_index(
      input logic [PIXEL_W-1:0]     pixel,
      input logic [PHASE_W-1:0]     col,
      input logic [PHASE_W-1:0]     row,
      input logic [STRENGTH_W-1:0]  strength
   );
      logic [PHASE_W-1:0]   diag;
      logic [THRESH_W-1:0]  threshold;
      logic [THRESH_W-1:0]  keep;
      longint unsigned      m;
      longint unsigned      offset;
      int unsigned          red;
      int unsigned          green;
      int unsigned          blue;
      int unsigned          sum;
      // Bayer threshold: column bits and column^row bits interleaved, reversed.
      diag      = col ^ row;
      threshold = {diag[0], col[0], diag[1], col[1], diag[2], col[2]};
      keep      = THRESH_ALL & ~(THRESH_ALL >> strength);
      m         = 64'(threshold & keep);
      offset    = OFFSET_CEIL - fourth_root_floor((m * m * m) << 46);
      red   = channel_level(pixel[7:0], RED_LEVELS, offset);
      green = channel_level(pixel[15:8], GREEN_LEVELS, offset);
      blue  = channel_level(pixel[23:16], BLUE_LEVELS, offset);
      sum   = red * GREEN_LEVELS * BLUE_LEVELS + green * BLUE_LEVELS + blue;
      return sum[INDEX_W-1:0];
   endfunction

   // Track the strength register, predict each accepted pixel and check each index.
   always @(posedge clock) begin
      if (reset) begin
         strength_copy <= STRENGTH_RESET;
         expected_results.delete();
         in_flight <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == STRENGTH_ADDR) begin
            if (csr_pwrite) begin
               strength_copy <= csr_pwdata[STRENGTH_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(strength_copy)) begin
               $display("%0t: strength read mismatch: expected %0d, got %0d",
                        $time, strength_copy, csr_prdata);
               failures = failures + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            fresh.pixel = req_tdata[PIXEL_W-1:0];
            fresh.col   = req_tdata[PIXEL_W +: PHASE_W];
            fresh.row   = req_tdata[PIXEL_W + PHASE_W +: PHASE_W];
            fresh.index = predict_palette_index(fresh.pixel, fresh.col, fresh.row,
                                                strength_copy);
            expected_results.push_back(fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected palette index transaction: expected none, got %0d",
                        $time, rsp_tdata);
               failures = failures + 1;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_tdata !== oldest.index) begin
                  $display("%0t: palette index mismatch for pixel %h at (%0d,%0d): %s %0d, %s %0d",
                           $time, oldest.pixel, oldest.col, oldest.row,
                           "expected", oldest.index, "got", rsp_tdata);
                  failures = failures + 1;
               end
            end
         end
         in_flight <= expected_results.size();
      end
   end

endmodule

### test/testbench.sv
module testbench;
   import odp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] STRENGTH_ADDR = CSR_ADDR_W'(4 * CSR_STRENGTH_INDEX);
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 48;
   localparam int CYCLE_LIMIT = 200000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // [31:0] pixel_rgba, [34:32] column_phase, [37:35] row_phase, [39:38] zero
   logic [REQ_DATA_W-1:0]    req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // [7:0] palette_index
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   int                       failures;
   int                       in_flight;
   int                       cycle_count = 0;
   bit                       sender_idle;
   bit                       receiver_idle;
   int                       long_hold = 0;

   ordered_dither_rgb_to_palette_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dither_index_checker #(.STRENGTH_ADDR(STRENGTH_ADDR)) index_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .in_flight   (in_flight)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ordered_dither_rgb_to_palette_core] ERROR");
         $finish;
      end
   end

   // Offer one pixel transaction after a random gap; returns at the falling edge after
   // acceptance with tvalid still high, so back-to-back pixels never drop tvalid.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic [PHASE_W-1:0] col,
                             input logic [PHASE_W-1:0] row);
      int gap;
      gap = sender_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({row, col, pixel});
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // One register access on the configuration port, setup then access phase, after which
   // the bus returns to idle.
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= STRENGTH_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly random pixels; a third of them have channels pinned to black or full scale.
   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [PIXEL_W-1:0] pixel;
      pixel = $urandom();
      if ($urandom_range(0, 2) == 0) begin
         for (int lane = 0; lane < 3; lane++) begin
            case ($urandom_range(0, 3))
               0: pixel[8*lane +: 8] = 8'h00;
               1: pixel[8*lane +: 8] = 8'hFF;
               default: ;
            endcase
         end
      end
      return pixel;
   endfunction

   // Receiver: random stalls per transaction, plus one long hold requested by the stimulus.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            stall     = long_hold;
            long_hold = 0;
         end else begin
            stall = receiver_idle ? $urandom_range(0, 8) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Stimulus: one phase per strength setting, draining the pipeline between phases.
   initial begin
      logic [STRENGTH_W-1:0] strength_plan [PHASES];
      logic [CSR_DATA_W-1:0] wdata;
      strength_plan = '{3'd6, 3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle   = (phase % 3) != 1;
         receiver_idle = (phase % 4) != 2;

         // The first phase runs at the reset strength; later ones write a new one,
         // sometimes with junk above the register's three bits.
         if (phase > 0) begin
            wdata = CSR_DATA_W'(strength_plan[phase]);
            if (phase % 2 == 1) begin
               wdata = ($urandom() & ~CSR_DATA_W'(7)) | wdata;
            end
            csr_access(1'b1, wdata);
         end
         csr_access(1'b0, '0);

         if (phase == 0) begin
            // Corners of the color cube, single channels, alpha alone, and mid grays.
            send_pixel(32'h0000_0000, 3'd0, 3'd0);
            send_pixel(32'hFFFF_FFFF, 3'd7, 3'd7);
            send_pixel(32'h00FF_FFFF, 3'd0, 3'd7);
            send_pixel(32'hFF00_0000, 3'd7, 3'd0);
            send_pixel(32'h0000_00FF, 3'd1, 3'd2);
            send_pixel(32'h0000_FF00, 3'd2, 3'd4);
            send_pixel(32'h00FF_0000, 3'd4, 3'd1);
            send_pixel(32'h0080_8080, 3'd3, 3'd5);
            send_pixel(32'h0001_0101, 3'd5, 3'd3);
            send_pixel(32'h00FE_FEFE, 3'd6, 3'd6);
            send_pixel(32'h7F00_FF01, 3'd2, 3'd2);
            // Every column phase against a changing row phase.
            for (int col = 0; col < 8; col++) begin
               send_pixel(32'h007F_7F7F, PHASE_W'(col), PHASE_W'(7 - col));
            end
         end

         // Flood the block while the receiver holds off, so the input stalls.
         if (phase == 4) begin
            sender_idle = 1'b0;
            long_hold   = 40;
         end

         for (int item = 0; item < PHASE_ITEMS; item++) begin
            send_pixel(random_pixel(), PHASE_W'($urandom_range(0, 7)),
                       PHASE_W'($urandom_range(0, 7)));
         end

         // Let every palette index of this phase drain before touching the register.
         req_tvalid <= 1'b0;
         wait (in_flight == 0);
         @(negedge clock);
      end

      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("[ordered_dither_rgb_to_palette_core] OK");
      end else begin
         $display("[ordered_dither_rgb_to_palette_core] ERROR");
      end
      $finish;
   end

endmodule
